### rtl/core/sog_pkg.sv
// ----------------------------------------------------------------------------
// Smoothing objective gradient package
// Shared widths, sequencer codes and arithmetic helpers for the first-difference
// smoothing gradient block.
// ----------------------------------------------------------------------------
package sog_pkg;

    localparam int SAMPLE_WIDTH    = 32;
    localparam int WEIGHT_WIDTH    = 32;
    localparam int VALUE_WIDTH     = 64;
    localparam int POSITION_WIDTH  = 16;
    localparam int MAX_LENGTH_DEF  = 65536;

    // Reset weight is 1.0 in Q16.16.
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 32'h0001_0000;

    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    localparam logic KIND_GRADIENT  = 1'b0;
    localparam logic KIND_OBJECTIVE = 1'b1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic        [WEIGHT_WIDTH-1:0] weight_t;
    typedef logic signed [VALUE_WIDTH-1:0]  value_t;
    typedef logic        [VALUE_WIDTH-1:0]  accum_t;
    typedef logic        [POSITION_WIDTH-1:0] position_t;

    // Step of the item held in the input register.
    typedef enum logic [2:0] {
        PH_STEP      = 3'b001,
        PH_LAST_GRAD = 3'b010,
        PH_OBJECTIVE = 3'b100
    } phase_t;

    // Low 64 bits of the square of a 33-bit difference.
    function automatic accum_t square_low(input logic signed [SAMPLE_WIDTH:0] d);
        logic signed [2*SAMPLE_WIDTH+1:0] p;
        p = d * d;
        return p[VALUE_WIDTH-1:0];
    endfunction

    // Unsigned add that sticks at the all-ones value on overflow.
    function automatic accum_t sat_add(input accum_t a, input accum_t b);
        logic [VALUE_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_WIDTH] ? '1 : s[VALUE_WIDTH-1:0];
    endfunction

    // 2*lambda*diff + 2*(center)*2^16 in Q48.16, saturated to 64 bits.
    function automatic value_t grad_value(
        input weight_t                        w,
        input logic signed [SAMPLE_WIDTH+1:0] diff,
        input logic signed [SAMPLE_WIDTH:0]   center
    );
        logic signed [68:0] prod;
        logic signed [68:0] sum;
        prod = $signed({1'b0, w}) * diff;
        sum  = (prod <<< 1) + (69'(center) <<< 17);
        if (sum[68:63] == {6{sum[63]}})
            return sum[63:0];
        else if (sum[68])
            return VALUE_MIN;
        else
            return VALUE_MAX;
    endfunction

    // Combines the two partial products of lambda * roughness, drops the
    // 16 extra fraction bits and adds the fit term with saturation.
    function automatic value_t objective_value(
        input accum_t fit,
        input accum_t lo_pp,
        input accum_t hi_pp
    );
        logic [95:0]          r;
        accum_t               scaled;
        logic [VALUE_WIDTH:0] s;
        r      = {hi_pp, 32'd0} + {32'd0, lo_pp};
        scaled = (r[95:80] != 16'd0) ? '1 : r[79:16];
        s      = {1'b0, fit} + {1'b0, scaled};
        if (s[VALUE_WIDTH] || s[VALUE_WIDTH-1])
            return VALUE_MAX;
        else
            return s[VALUE_WIDTH-1:0];
    endfunction

endpackage

### rtl/core/smoothing_objective_gradient.sv
// ----------------------------------------------------------------------------
// Smoothing objective gradient
// Streams pairs (estimate, observation) and returns the gradient of the
// first-difference smoothing objective for each element, then the objective.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     in_valid / in_stall        estimate, observation, final_pair
//  output    out_valid / out_stall      kind, position, value, run_end
//  config    cfg_write_enable           cfg_write_data (smoothing weight)
//
// A non-last item leaves the input register as the next one enters, so one
// item enters per cycle while the output is not stalled. The last item of a
// run passes through three steps: middle gradient, last gradient, and the
// objective, whose 32x64 product is split into two 32x32 halves. A result
// reaches the output in the cycle after its step. Reset clears the window
// and sums and sets the weight register to 1.0. A stalled output holds its
// result, and the input stalls while the input register cannot advance.
// ----------------------------------------------------------------------------
module smoothing_objective_gradient #(
    parameter int MAX_LENGTH = sog_pkg::MAX_LENGTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_write_enable,
    input  sog_pkg::weight_t    cfg_write_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  sog_pkg::sample_t    estimate,
    input  sog_pkg::sample_t    observation,
    input  logic                final_pair,

    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output sog_pkg::position_t  position,
    output sog_pkg::value_t     value,
    output logic                run_end
);
    import sog_pkg::*;

    localparam int CountWidth  = $clog2(MAX_LENGTH + 1);
    localparam int PosExtWidth = (CountWidth > POSITION_WIDTH) ? CountWidth : POSITION_WIDTH;
    localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MAX_LENGTH);

    weight_t               weight_reg;

    logic                  s1_valid_reg, s1_valid_next;
    sample_t               s1_x_reg;
    sample_t               s1_y_reg;
    logic                  s1_last_reg;
    phase_t                phase_reg, phase_next;

    sample_t               older_reg, older_next;
    sample_t               middle_reg, middle_next;
    sample_t               middle_obs_reg, middle_obs_next;
    logic [CountWidth-1:0] count_reg, count_next;
    accum_t                fit_reg, fit_next;
    accum_t                rough_reg, rough_next;
    accum_t                lo_pp_reg;
    accum_t                hi_pp_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg, kind_next;
    position_t             position_reg, position_next;
    value_t                value_reg, value_next;
    logic                  run_end_reg, run_end_next;

    logic                  out_free;
    logic                  step_go;
    logic                  s1_done;
    logic                  in_fire;
    logic                  has_one;
    logic                  has_two;
    logic                  emit;

    logic signed [SAMPLE_WIDTH+1:0] diff_mid;
    logic signed [SAMPLE_WIDTH+1:0] diff_last;
    logic signed [SAMPLE_WIDTH+1:0] grad_diff;
    logic signed [SAMPLE_WIDTH:0]   grad_center;
    value_t                          grad;
    logic [PosExtWidth-1:0]          count_ext;
    logic [PosExtWidth-1:0]          count_prev_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign step_go  = s1_valid_reg && out_free;
    assign s1_done  = step_go && (!s1_last_reg || phase_reg == PH_OBJECTIVE);
    assign in_stall = s1_valid_reg && !s1_done;
    assign in_fire  = in_valid && !in_stall;

    assign has_one = (count_reg != '0);
    assign has_two = (count_reg > CountWidth'(1));

    assign count_ext      = PosExtWidth'(count_reg);
    assign count_prev_ext = count_ext - PosExtWidth'(1);

    // Interior element uses both neighbor differences; the first uses only
    // the right one.
    assign diff_mid = (34'(middle_reg) - 34'(s1_x_reg))
                    + (has_two ? (34'(middle_reg) - 34'(older_reg)) : 34'sd0);
    assign diff_last = has_one ? (34'(s1_x_reg) - 34'(middle_reg)) : 34'sd0;

    always_comb
    begin
        if (phase_reg == PH_STEP)
        begin
            grad_diff   = diff_mid;
            grad_center = 33'(middle_reg) - 33'(middle_obs_reg);
        end
        else
        begin
            grad_diff   = diff_last;
            grad_center = 33'(s1_x_reg) - 33'(s1_y_reg);
        end
    end

    assign grad = grad_value(weight_reg, grad_diff, grad_center);

    always_comb
    begin
        phase_next      = phase_reg;
        older_next      = older_reg;
        middle_next     = middle_reg;
        middle_obs_next = middle_obs_reg;
        count_next      = count_reg;
        fit_next        = fit_reg;
        rough_next      = rough_reg;
        emit            = 1'b0;
        kind_next       = KIND_GRADIENT;
        position_next   = count_prev_ext[POSITION_WIDTH-1:0];
        value_next      = grad;
        run_end_next    = 1'b0;

        if (step_go)
        begin
            unique case (phase_reg)
                PH_STEP:
                begin
                    emit     = has_one;
                    fit_next = sat_add(fit_reg,
                                       square_low(33'(s1_x_reg) - 33'(s1_y_reg)));
                    if (has_one)
                        rough_next = sat_add(rough_reg,
                                             square_low(33'(s1_x_reg) - 33'(middle_reg)));
                    if (s1_last_reg)
                        phase_next = PH_LAST_GRAD;
                    else
                    begin
                        older_next      = middle_reg;
                        middle_next     = s1_x_reg;
                        middle_obs_next = s1_y_reg;
                        if (count_reg < CountLimit)
                            count_next = count_reg + CountWidth'(1);
                    end
                end
                PH_LAST_GRAD:
                begin
                    emit          = 1'b1;
                    position_next = count_ext[POSITION_WIDTH-1:0];
                    phase_next    = PH_OBJECTIVE;
                end
                PH_OBJECTIVE:
                begin
                    emit            = 1'b1;
                    kind_next       = KIND_OBJECTIVE;
                    position_next   = '0;
                    value_next      = objective_value(fit_reg, lo_pp_reg, hi_pp_reg);
                    run_end_next    = 1'b1;
                    phase_next      = PH_STEP;
                    older_next      = '0;
                    middle_next     = '0;
                    middle_obs_next = '0;
                    count_next      = '0;
                    fit_next        = '0;
                    rough_next      = '0;
                end
                default:
                begin
                    phase_next = PH_STEP;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_done)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg     <= WEIGHT_RESET;
            s1_valid_reg   <= 1'b0;
            phase_reg      <= PH_STEP;
            older_reg      <= '0;
            middle_reg     <= '0;
            middle_obs_reg <= '0;
            count_reg      <= '0;
            fit_reg        <= '0;
            rough_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
                weight_reg <= cfg_write_data;
            s1_valid_reg   <= s1_valid_next;
            phase_reg      <= phase_next;
            older_reg      <= older_next;
            middle_reg     <= middle_next;
            middle_obs_reg <= middle_obs_next;
            count_reg      <= count_next;
            fit_reg        <= fit_next;
            rough_reg      <= rough_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg    <= estimate;
            s1_y_reg    <= observation;
            s1_last_reg <= final_pair;
        end
        // The roughness sum is final once the last item's first step is done.
        if (step_go && phase_reg == PH_LAST_GRAD)
        begin
            lo_pp_reg <= {32'd0, weight_reg} * {32'd0, rough_reg[31:0]};
            hi_pp_reg <= {32'd0, weight_reg} * {32'd0, rough_reg[63:32]};
        end
        if (out_free && emit)
        begin
            kind_reg     <= kind_next;
            position_reg <= position_next;
            value_reg    <= value_next;
            run_end_reg  <= run_end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign position  = position_reg;
    assign value     = value_reg;
    assign run_end   = run_end_reg;

    // The last item of a run holds the input until its objective step.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && phase_reg != PH_OBJECTIVE |-> in_stall)
        else $error("input accepted during the tail of a run");

    // The sequencer leaves its first step only with an item in hand.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> phase_reg == PH_STEP)
        else $error("sequencer away from its first step with no item");

    // Closing a run clears the element count and both sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_go && phase_reg == PH_OBJECTIVE
        |=> count_reg == '0 && fit_reg == '0 && rough_reg == '0)
        else $error("run state not cleared after the objective");

endmodule

### tb/smoothing_objective_gradient_test.sv
// ----------------------------------------------------------------------------
// Smoothing objective gradient testbench
// Streams runs of (estimate, observation) pairs into the block and predicts
// every gradient element and every run objective. Each accepted result is
// compared field by field with the oldest prediction. Idle and stall patterns
// change from phase to phase, and the smoothing weight is rewritten between
// runs while the block is idle.
// ----------------------------------------------------------------------------
module smoothing_objective_gradient_test;
    import sog_pkg::*;

    localparam int      CYCLE_LIMIT   = 1_000_000;
    localparam int      SETTLE_CYCLES = 8;
    localparam int      HOLD_CYCLES   = 80;
    localparam int      PRINT_LIMIT   = 40;
    localparam int      PHASE_ITEMS   = 95;
    localparam sample_t SAMPLE_MAX    = 32'sh7FFF_FFFF;
    localparam sample_t SAMPLE_MIN    = 32'sh8000_0000;
    localparam weight_t WEIGHT_FULL   = 32'hFFFF_FFFF;

    typedef struct {
        logic      kind;
        position_t position;
        value_t    value;
        logic      run_end;
    } result_t;

    class smoothing_scoreboard;
        weight_t    weight;
        longint     prev2_x;
        longint     prev_x;
        longint     prev_y;
        int         held;
        accum_t     fit_acc;
        accum_t     rough_acc;
        result_t    awaited_values[$];
        int         errors;

        function new();
            weight    = WEIGHT_RESET;
            prev2_x   = 0;
            prev_x    = 0;
            prev_y    = 0;
            held      = 0;
            fit_acc   = '0;
            rough_acc = '0;
            errors    = 0;
        endfunction

        function accum_t add_sticky(accum_t a, accum_t b);
            logic [VALUE_WIDTH:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[VALUE_WIDTH] ? '1 : s[VALUE_WIDTH-1:0];
        endfunction

        function accum_t square_of(longint d);
            accum_t m;
            m = (d < 0) ? -d : d;
            return m * m;
        endfunction

        // Exact 2*lambda*diff + 2*(center - obs) in Q48.16, then saturated.
        function value_t gradient_term(longint diff, longint center, longint obs);
            logic signed [127:0] w_wide;
            logic signed [127:0] d_wide;
            logic signed [127:0] c_wide;
            logic signed [127:0] total;
            w_wide = {96'd0, weight};
            d_wide = diff;
            c_wide = center - obs;
            total  = 2 * w_wide * d_wide + (c_wide <<< 17);
            if (total[127:63] == {65{total[63]}})
                return total[63:0];
            return total[127] ? VALUE_MIN : VALUE_MAX;
        endfunction

        function void note_pair(sample_t est, sample_t obs, logic last);
            longint      x;
            longint      y;
            longint      diff;
            logic [95:0] product;
            accum_t      scaled;
            accum_t      total;
            x = est;
            y = obs;
            fit_acc = add_sticky(fit_acc, square_of(x - y));
            // The element held in the window is complete once its right
            // neighbor arrives.
            if (held > 0)
            begin
                diff = prev_x - x;
                if (held > 1)
                    diff += prev_x - prev2_x;
                rough_acc = add_sticky(rough_acc, square_of(x - prev_x));
                awaited_values.push_back(result_t'{KIND_GRADIENT, position_t'(held - 1),
                                                   gradient_term(diff, prev_x, prev_y),
                                                   1'b0});
            end
            if (last)
            begin
                diff = (held > 0) ? x - prev_x : 0;
                awaited_values.push_back(result_t'{KIND_GRADIENT, position_t'(held),
                                                   gradient_term(diff, x, y), 1'b0});
                product = weight * rough_acc;
                scaled  = (product[95:80] != 16'd0) ? '1 : product[79:16];
                total   = add_sticky(fit_acc, scaled);
                if (total > VALUE_MAX)
                    total = VALUE_MAX;
                awaited_values.push_back(result_t'{KIND_OBJECTIVE, position_t'(0), total,
                                                   1'b1});
                prev2_x   = 0;
                prev_x    = 0;
                prev_y    = 0;
                held      = 0;
                fit_acc   = '0;
                rough_acc = '0;
            end
            else
            begin
                prev2_x = prev_x;
                prev_x  = x;
                prev_y  = y;
                if (held < MAX_LENGTH_DEF)
                    held++;
            end
        endfunction

        function void report(string field, logic [63:0] want_v, logic [63:0] got_v);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, field, want_v, got_v);
        endfunction

        function void check_output(logic k, position_t p, value_t v, logic e);
            result_t want;
            if (awaited_values.size() == 0)
            begin
                errors++;
                if (errors <= PRINT_LIMIT)
                    $display("%0t: result with nothing pending, expected none, actual %h",
                             $time, v);
                return;
            end
            want = awaited_values.pop_front();
            if (k !== want.kind)
                report("kind", want.kind, k);
            if (p !== want.position)
                report("position", want.position, p);
            if (v !== want.value)
                report("value", want.value, v);
            if (e !== want.run_end)
                report("run_end", want.run_end, e);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_enable;
    weight_t     cfg_write_data;
    logic        in_valid;
    logic        in_stall;
    sample_t     estimate;
    sample_t     observation;
    logic        final_pair;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    position_t   position;
    value_t      value;
    logic        run_end;

    smoothing_scoreboard sb;
    int unsigned cycle_count = 0;
    int          send_idle_pct;
    int          stall_pct;
    logic        hold_request;
    int          hold_left;

    smoothing_objective_gradient dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .estimate         (estimate),
        .observation      (observation),
        .final_pair       (final_pair),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .position         (position),
        .value            (value),
        .run_end          (run_end)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.note_pair(estimate, observation, final_pair);
            if (out_valid && !out_stall)
                sb.check_output(kind, position, value, run_end);
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(9)) inside
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            [3:5]:   return sample_t'($urandom);
            default: return sample_t'(int'($urandom_range(0, 1048576)) - 524288);
        endcase
    endfunction

    function automatic weight_t pick_weight();
        case ($urandom_range(4))
            0:       return '0;
            1:       return WEIGHT_FULL;
            2:       return WEIGHT_RESET;
            3:       return weight_t'($urandom_range(0, 262144));
            default: return weight_t'($urandom);
        endcase
    endfunction

    // Called and returns at a falling edge.
    task automatic send_pair(input sample_t x, input sample_t y, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        estimate    <= x;
        observation <= y;
        final_pair  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.awaited_values.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_weight(input weight_t w);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= w;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        sb.weight = w;
    endtask

    // Full-scale alternation drives both sums into saturation.
    task automatic send_alternating();
        for (int k = 0; k < 4; k++)
            send_pair(k[0] ? SAMPLE_MIN : SAMPLE_MAX, k[0] ? SAMPLE_MAX : SAMPLE_MIN, k == 3);
    endtask

    initial
    begin
        int send_idle_plan[4];
        int stall_plan[4];
        int sent;
        int len;

        send_idle_plan   = '{0, 59, 0, 31};
        stall_plan       = '{0, 0, 59, 31};
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data   = '0;
        in_valid         = 1'b0;
        estimate         = '0;
        observation      = '0;
        final_pair       = 1'b0;
        out_stall        = 1'b0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_request     = 1'b0;
        hold_left        = 0;
        sb               = new();

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Lone pairs take no neighbor terms.
        send_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_alternating();
        drain();
        write_weight(WEIGHT_FULL);
        send_alternating();
        send_pair(32'sh0001_0000, '0, 1'b0);
        send_pair(32'sh0002_0000, 32'sh0001_0000, 1'b0);
        send_pair(-32'sh0001_0000, '0, 1'b1);
        drain();
        write_weight('0);
        send_pair(-32'sh1, 32'sh1, 1'b0);
        send_pair('0, SAMPLE_MAX, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            send_idle_pct = send_idle_plan[phase];
            stall_pct     = stall_plan[phase];
            write_weight(pick_weight());
            // The receiver holds off while items keep coming, so the block backs up.
            if (phase == 0)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                if ($urandom_range(3) == 0)
                begin
                    drain();
                    write_weight(pick_weight());
                end
                for (int k = 0; k < len; k++)
                    send_pair(pick_sample(), pick_sample(), k == len - 1);
                sent += len;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sog_pkg.sv
rtl/core/smoothing_objective_gradient.sv
tb/smoothing_objective_gradient_test.sv
